// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low).
`define HFTQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define HFTQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/hftq_pkg.sv
// Shared types and constants for the heightfield triangle height query block.
// No dependencies; imported by every module of the block except hftq_ram.
package hftq_pkg;

    // Fixed field widths of the item payloads
    localparam int QUERY_W       = 16;
    localparam int CELL_IDX_W    = 16;
    localparam int HEIGHT_BYTE_W = 8;
    localparam int HEIGHT_W      = 13;
    localparam int SIDE_W        = 9;
    localparam int CFG_IDX_W     = 1;

    localparam logic [SIDE_W-1:0]   SIDE_RESET = 9'd256;
    localparam logic [HEIGHT_W-1:0] HEIGHT_SAT = 13'h1FFF;

    // Vertex world height is the raw byte over this divisor
    localparam int DIVISOR = 10;

    typedef enum logic [0:0] {
        MODE_WRITE = 1'b0,
        MODE_QUERY = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH = 1'b0,
        REG_GRID_DEPTH = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_mode                    mode;
        logic [CELL_IDX_W-1:0]    cell_index;
        logic [HEIGHT_BYTE_W-1:0] height_value;
        logic [QUERY_W-1:0]       query_x;
        logic [QUERY_W-1:0]       query_z;
    } t_in_item;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                out_of_range;
    } t_out_item;

    // Height store write strobe: enable and bank (index parity)
    typedef struct packed {
        logic en;
        logic odd;
    } t_wr_ctrl;

    // Query control handed from address stage to interpolation stage
    typedef struct packed {
        logic valid;
        logic out_of_range;
        logic upper;      // upper-right triangle of the cell
        logic row0_odd;   // index of the (cx, cz) vertex is odd
        logic row1_odd;   // index of the (cx, cz+1) vertex is odd
    } t_tri_ctrl;

endpackage

// File: hw/rtl/hftq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the height store banks.
module hftq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds while disabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/hftq_addr.sv
// Front pipeline: input register, cell decode, range check and store addressing.
// Depends on hftq_pkg; feeds the store banks and hftq_interp.
module hftq_addr import hftq_pkg::*; #(
    parameter  int MAX_SIDE      = 256,
    parameter  int FRACTION_BITS = 8,
    localparam int STORE_CELLS   = MAX_SIDE * MAX_SIDE,
    localparam int BANK_AW       = $clog2((STORE_CELLS + 1) / 2)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_item,
    input  logic [SIDE_W-1:0]        i_grid_width,
    input  logic [SIDE_W-1:0]        i_grid_depth,
    input  logic                     i_s3_ready,
    output t_wr_ctrl                 o_wr,
    output logic [BANK_AW-1:0]       o_wr_addr,
    output logic [HEIGHT_BYTE_W-1:0] o_wr_data,
    output logic [BANK_AW-1:0]       o_row0_even_addr,
    output logic [BANK_AW-1:0]       o_row0_odd_addr,
    output logic [BANK_AW-1:0]       o_row1_even_addr,
    output logic [BANK_AW-1:0]       o_row1_odd_addr,
    output t_tri_ctrl                o_ctrl,
    output logic [FRACTION_BITS-1:0] o_fx,
    output logic [FRACTION_BITS-1:0] o_fz
);

    localparam int IDX_W = $clog2(STORE_CELLS);
    localparam int CW    = (QUERY_W - FRACTION_BITS > 0) ? QUERY_W - FRACTION_BITS : 1;
    localparam int PW    = CW + SIDE_W;
    localparam int AXW   = (PW + 1 > IDX_W + 1) ? PW + 1 : IDX_W + 1;
    localparam int WW    = FRACTION_BITS + 1;
    localparam int unsigned ONE = 1 << FRACTION_BITS;

    // ---------------- stage 1: accepted item ----------------
    logic     r_s1_valid;
    t_in_item r_s1_item;
    logic     s1_ready;
    logic     s2_ready;

    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_item <= i_in_item;
        end
    end

    // Clamp grid size, split the point into cell and fraction, row offset
    logic [SIDE_W-1:0]        w_eff;
    logic [SIDE_W-1:0]        d_eff;
    logic [31:0]              qx_sh;
    logic [31:0]              qz_sh;
    logic [31:0]              wr_ext;
    logic [CW-1:0]            n_cx;
    logic [CW-1:0]            cz;
    logic [PW-1:0]            n_prod;
    logic                     n_oor;
    logic                     n_wr_ok;
    logic [IDX_W-1:0]         n_wr_idx;

    always_comb begin
        w_eff    = (32'(i_grid_width) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : i_grid_width;
        d_eff    = (32'(i_grid_depth) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : i_grid_depth;
        qx_sh    = 32'(r_s1_item.query_x) >> FRACTION_BITS;
        qz_sh    = 32'(r_s1_item.query_z) >> FRACTION_BITS;
        n_cx     = qx_sh[CW-1:0];
        cz       = qz_sh[CW-1:0];
        n_prod   = PW'(cz) * PW'(w_eff);
        // far corner must lie inside the grid; also covers sizes below two
        n_oor    = ((32'(n_cx) + 32'd1) >= 32'(w_eff)) ||
                   ((32'(cz) + 32'd1) >= 32'(d_eff));
        wr_ext   = 32'(r_s1_item.cell_index);
        n_wr_ok  = wr_ext < 32'(STORE_CELLS);
        n_wr_idx = wr_ext[IDX_W-1:0];
    end

    // ---------------- stage 2: addresses ----------------
    logic                     r_s2_valid;
    logic                     r_s2_query;
    logic                     r_s2_wr_ok;
    logic [IDX_W-1:0]         r_s2_wr_idx;
    logic [HEIGHT_BYTE_W-1:0] r_s2_wr_data;
    logic [CW-1:0]            r_s2_cx;
    logic [SIDE_W-1:0]        r_s2_w;
    logic [PW-1:0]            r_s2_prod;
    logic [FRACTION_BITS-1:0] r_s2_fx;
    logic [FRACTION_BITS-1:0] r_s2_fz;
    logic                     r_s2_oor;

    // write items retire here and never wait on the back end
    assign s2_ready = !r_s2_valid || !r_s2_query || i_s3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_s2_query   <= (r_s1_item.mode == MODE_QUERY);
            r_s2_wr_ok   <= n_wr_ok;
            r_s2_wr_idx  <= n_wr_idx;
            r_s2_wr_data <= r_s1_item.height_value;
            r_s2_cx      <= n_cx;
            r_s2_w       <= w_eff;
            r_s2_prod    <= n_prod;
            r_s2_fx      <= r_s1_item.query_x[FRACTION_BITS-1:0];
            r_s2_fz      <= r_s1_item.query_z[FRACTION_BITS-1:0];
            r_s2_oor     <= n_oor;
        end
    end

    // Row 0 copy serves (cx,cz),(cx+1,cz); row 1 copy serves (cx,cz+1),(cx+1,cz+1).
    // Within a copy, even and odd indexes sit in separate banks.
    logic [AXW-1:0] idx0;
    logic [AXW-1:0] idx1;
    logic [AXW-1:0] idx0_nx;
    logic [AXW-1:0] idx1_nx;

    always_comb begin
        idx0    = AXW'(r_s2_prod) + AXW'(r_s2_cx);
        idx1    = idx0 + AXW'(r_s2_w);
        idx0_nx = idx0 + AXW'(1);
        idx1_nx = idx1 + AXW'(1);
    end

    assign o_row0_even_addr = idx0_nx[BANK_AW:1];
    assign o_row0_odd_addr  = idx0[BANK_AW:1];
    assign o_row1_even_addr = idx1_nx[BANK_AW:1];
    assign o_row1_odd_addr  = idx1[BANK_AW:1];

    always_comb begin
        o_ctrl.valid        = r_s2_valid && r_s2_query;
        o_ctrl.out_of_range = r_s2_oor;
        o_ctrl.upper        = (WW'(r_s2_fx) + WW'(r_s2_fz)) > WW'(ONE);
        o_ctrl.row0_odd     = idx0[0];
        o_ctrl.row1_odd     = idx1[0];
    end

    assign o_fx = r_s2_fx;
    assign o_fz = r_s2_fz;

    // Store write, same stage as the reads so order between items holds
    assign o_wr.en   = r_s2_valid && !r_s2_query && r_s2_wr_ok;
    assign o_wr.odd  = r_s2_wr_idx[0];
    assign o_wr_addr = r_s2_wr_idx[BANK_AW:1];
    assign o_wr_data = r_s2_wr_data;

endmodule

// File: hw/rtl/hftq_interp.sv
// Back pipeline: corner select, weighting, sum, divide by ten and output register.
// Depends on hftq_pkg; fed by hftq_addr and the store banks.
module hftq_interp import hftq_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tri_ctrl                i_ctrl,
    input  logic [FRACTION_BITS-1:0] i_fx,
    input  logic [FRACTION_BITS-1:0] i_fz,
    output logic                     o_s3_ready,
    input  logic [HEIGHT_BYTE_W-1:0] i_row0_even,
    input  logic [HEIGHT_BYTE_W-1:0] i_row0_odd,
    input  logic [HEIGHT_BYTE_W-1:0] i_row1_even,
    input  logic [HEIGHT_BYTE_W-1:0] i_row1_odd,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_item
);

    localparam int WW  = FRACTION_BITS + 1;              // weight width
    localparam int PRW = FRACTION_BITS + HEIGHT_BYTE_W + 1;  // product width
    localparam int NW  = FRACTION_BITS + HEIGHT_BYTE_W;  // weighted sum width
    localparam int MW  = NW - 3;                         // quotient width
    localparam int unsigned ONE   = 1 << FRACTION_BITS;
    localparam int unsigned RECIP = (1 << NW) / DIVISOR;

    // ready chain, back to front
    logic r_s4_valid;
    logic r_s5_valid;
    logic r_s6_valid;
    logic r_out_valid;
    logic out_ready;
    logic s6_ready;
    logic s5_ready;
    logic s4_ready;
    logic s3_ready;

    t_tri_ctrl r_s3_ctrl;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s6_ready   = !r_s6_valid || out_ready;
    assign s5_ready   = !r_s5_valid || s6_ready;
    assign s4_ready   = !r_s4_valid || s5_ready;
    assign s3_ready   = !r_s3_ctrl.valid || s4_ready;
    assign o_s3_ready = s3_ready;

    // ---------------- stage 3: store data arrives ----------------
    logic [FRACTION_BITS-1:0] r_s3_fx;
    logic [FRACTION_BITS-1:0] r_s3_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctrl <= '0;
        end else if (s3_ready) begin
            r_s3_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready) begin
            r_s3_fx <= i_fx;
            r_s3_fz <= i_fz;
        end
    end

    // Pick the three corners and their weights, then multiply
    logic [HEIGHT_BYTE_W-1:0] h_c;
    logic [HEIGHT_BYTE_W-1:0] h_10;
    logic [HEIGHT_BYTE_W-1:0] h_01;
    logic [HEIGHT_BYTE_W-1:0] h_11;
    logic [HEIGHT_BYTE_W-1:0] h_a;
    logic [HEIGHT_BYTE_W-1:0] h_b;
    logic [HEIGHT_BYTE_W-1:0] h_cc;
    logic [WW-1:0]            w_a;
    logic [WW-1:0]            w_b;
    logic [WW-1:0]            w_c;
    logic [WW-1:0]            fx_w;
    logic [WW-1:0]            fz_w;
    logic [PRW-1:0]           n_pa;
    logic [PRW-1:0]           n_pb;
    logic [PRW-1:0]           n_pc;

    always_comb begin
        h_c  = r_s3_ctrl.row0_odd ? i_row0_odd  : i_row0_even;
        h_10 = r_s3_ctrl.row0_odd ? i_row0_even : i_row0_odd;
        h_01 = r_s3_ctrl.row1_odd ? i_row1_odd  : i_row1_even;
        h_11 = r_s3_ctrl.row1_odd ? i_row1_even : i_row1_odd;
        fx_w = WW'(r_s3_fx);
        fz_w = WW'(r_s3_fz);
        if (r_s3_ctrl.upper) begin
            h_a  = h_01;
            w_a  = WW'(ONE) - fx_w;
            h_b  = h_11;
            w_b  = fx_w + fz_w - WW'(ONE);
            h_cc = h_10;
            w_c  = WW'(ONE) - fz_w;
        end else begin
            h_a  = h_c;
            w_a  = WW'(ONE) - fx_w - fz_w;
            h_b  = h_10;
            w_b  = fx_w;
            h_cc = h_01;
            w_c  = fz_w;
        end
        n_pa = PRW'(h_a) * PRW'(w_a);
        n_pb = PRW'(h_b) * PRW'(w_b);
        n_pc = PRW'(h_cc) * PRW'(w_c);
    end

    // ---------------- stage 4: products ----------------
    logic           r_s4_oor;
    logic [PRW-1:0] r_s4_pa;
    logic [PRW-1:0] r_s4_pb;
    logic [PRW-1:0] r_s4_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (s4_ready) begin
            r_s4_valid <= r_s3_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_ready) begin
            r_s4_oor <= r_s3_ctrl.out_of_range;
            r_s4_pa  <= n_pa;
            r_s4_pb  <= n_pb;
            r_s4_pc  <= n_pc;
        end
    end

    // weights sum to one unit, so the total stays below 256 units
    logic [PRW+1:0] sum_full;
    logic [NW-1:0]  n_sum;

    always_comb begin
        sum_full = (PRW+2)'(r_s4_pa) + (PRW+2)'(r_s4_pb) + (PRW+2)'(r_s4_pc);
        n_sum    = sum_full[NW-1:0];
    end

    // ---------------- stage 5: weighted sum ----------------
    logic          r_s5_oor;
    logic [NW-1:0] r_s5_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (s5_ready) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_ready) begin
            r_s5_oor <= r_s4_oor;
            r_s5_n   <= n_sum;
        end
    end

    // Quotient estimate by reciprocal; low by at most one
    logic [NW+MW-1:0] recip_prod;
    logic [MW-1:0]    n_q_est;

    always_comb begin
        recip_prod = (NW+MW)'(r_s5_n) * (NW+MW)'(RECIP);
        n_q_est    = recip_prod[NW+MW-1:NW];
    end

    // ---------------- stage 6: estimate ----------------
    logic          r_s6_oor;
    logic [NW-1:0] r_s6_n;
    logic [MW-1:0] r_s6_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (s6_ready) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s6_ready) begin
            r_s6_oor <= r_s5_oor;
            r_s6_n   <= r_s5_n;
            r_s6_q   <= n_q_est;
        end
    end

    // One correction step, saturation, and zero for points off the grid
    logic [NW:0]     rem;
    logic [MW-1:0]   q_fix;
    t_out_item       n_out_item;

    always_comb begin
        rem   = (NW+1)'(r_s6_n) - (NW+1)'(r_s6_q) * (NW+1)'(DIVISOR);
        q_fix = (rem >= (NW+1)'(DIVISOR)) ? r_s6_q + MW'(1) : r_s6_q;
        if (r_s6_oor) begin
            n_out_item.height       = '0;
            n_out_item.out_of_range = 1'b1;
        end else begin
            n_out_item.height       = (32'(q_fix) > 32'(HEIGHT_SAT)) ? HEIGHT_SAT
                                                                    : HEIGHT_W'(q_fix);
            n_out_item.out_of_range = 1'b0;
        end
    end

    // ---------------- output register ----------------
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hw/rtl/heightfield_triangle_height_query.sv
// Top level of the heightfield triangle height query block.
// Depends on hftq_pkg, hftq_ram, hftq_addr and hftq_interp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): a write item
//   (mode 0) stores one height byte at cell_index; a query item (mode 1)
//   asks for the terrain height at the Q8.8 point (query_x, query_z).
//   Output channel (o_out_valid / i_out_stall / o_out_item): one item per
//   query, in order; writes give none. Points whose cell reaches the last
//   row or column come back with out_of_range set and height zero.
//   Config port: i_cfg_wr_en writes grid_width (index 0) or grid_depth
//   (index 1); write only while no query is in flight.
// Timing:
//   One item per cycle sustained while the receiver does not stall. A query
//   passes two front stages, the store read, products, sum, the reciprocal
//   divide by ten and the output register. The height store is split into an
//   even and odd bank per row copy, so all corners of a cell are read together.
// Reset clears the pipeline valid bits and sets both grid sizes to 256; the
// store contents are not cleared. When the receiver stalls, the pipeline
// keeps filling its empty stages and stalls the input only once full.
module heightfield_triangle_height_query import hftq_pkg::*; #(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIDE_W-1:0]    i_cfg_data
);

    localparam int STORE_CELLS = MAX_SIDE * MAX_SIDE;
    localparam int BANK_DEPTH  = (STORE_CELLS + 1) / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    // Configuration registers
    logic [SIDE_W-1:0] r_grid_width;
    logic [SIDE_W-1:0] r_grid_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= SIDE_RESET;
            r_grid_depth <= SIDE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data;
                end
                REG_GRID_DEPTH: begin
                    r_grid_depth <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Front pipeline
    t_wr_ctrl                 wr;
    logic [BANK_AW-1:0]       wr_addr;
    logic [HEIGHT_BYTE_W-1:0] wr_data;
    logic [BANK_AW-1:0]       row0_even_addr;
    logic [BANK_AW-1:0]       row0_odd_addr;
    logic [BANK_AW-1:0]       row1_even_addr;
    logic [BANK_AW-1:0]       row1_odd_addr;
    t_tri_ctrl                tri_ctrl;
    logic [FRACTION_BITS-1:0] fx;
    logic [FRACTION_BITS-1:0] fz;
    logic                     s3_ready;

    hftq_addr #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_addr (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_item        (i_in_item),
        .i_grid_width     (r_grid_width),
        .i_grid_depth     (r_grid_depth),
        .i_s3_ready       (s3_ready),
        .o_wr             (wr),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .o_row0_even_addr (row0_even_addr),
        .o_row0_odd_addr  (row0_odd_addr),
        .o_row1_even_addr (row1_even_addr),
        .o_row1_odd_addr  (row1_odd_addr),
        .o_ctrl           (tri_ctrl),
        .o_fx             (fx),
        .o_fz             (fz)
    );

    // Height store: two copies (one per cell row), each split by index parity.
    // Every write goes to both copies.
    logic [HEIGHT_BYTE_W-1:0] row0_even;
    logic [HEIGHT_BYTE_W-1:0] row0_odd;
    logic [HEIGHT_BYTE_W-1:0] row1_even;
    logic [HEIGHT_BYTE_W-1:0] row1_odd;
    logic                     wr_even_en;
    logic                     wr_odd_en;

    assign wr_even_en = wr.en && !wr.odd;
    assign wr_odd_en  = wr.en && wr.odd;

    hftq_ram #(.WIDTH(HEIGHT_BYTE_W), .DEPTH(BANK_DEPTH)) u_row0_even (
        .i_clk     (i_clk),
        .i_wr_en   (wr_even_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (s3_ready),
        .i_rd_addr (row0_even_addr),
        .o_rd_data (row0_even)
    );

    hftq_ram #(.WIDTH(HEIGHT_BYTE_W), .DEPTH(BANK_DEPTH)) u_row0_odd (
        .i_clk     (i_clk),
        .i_wr_en   (wr_odd_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (s3_ready),
        .i_rd_addr (row0_odd_addr),
        .o_rd_data (row0_odd)
    );

    hftq_ram #(.WIDTH(HEIGHT_BYTE_W), .DEPTH(BANK_DEPTH)) u_row1_even (
        .i_clk     (i_clk),
        .i_wr_en   (wr_even_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (s3_ready),
        .i_rd_addr (row1_even_addr),
        .o_rd_data (row1_even)
    );

    hftq_ram #(.WIDTH(HEIGHT_BYTE_W), .DEPTH(BANK_DEPTH)) u_row1_odd (
        .i_clk     (i_clk),
        .i_wr_en   (wr_odd_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (s3_ready),
        .i_rd_addr (row1_odd_addr),
        .o_rd_data (row1_odd)
    );

    // Back pipeline
    hftq_interp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (tri_ctrl),
        .i_fx        (fx),
        .i_fz        (fz),
        .o_s3_ready  (s3_ready),
        .i_row0_even (row0_even),
        .i_row0_odd  (row0_odd),
        .i_row1_even (row1_even),
        .i_row1_odd  (row1_odd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: hw/rtl/hftq_checker.sv
// Port-level checker for the heightfield triangle height query block.
// Depends on hftq_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module hftq_checker import hftq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    // A stalled result stays offered
    `HFTQ_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid, "result dropped while stalled")

    // A stalled result keeps its value
    `HFTQ_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall |=> $stable(i_out_item), "result changed while stalled")

    // Input only backs up when the output side is held
    `HFTQ_ASSERT(a_backpressure, i_clk, i_rst_n, i_in_stall |-> i_out_valid && i_out_stall, "input stalled with output free")

    // Points off the grid carry no height
    `HFTQ_ASSERT(a_oor_zero, i_clk, i_rst_n, i_out_valid && i_out_item.out_of_range |-> i_out_item.height == '0, "height set on out-of-range result")

    // Reset empties the pipeline
    `HFTQ_ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> !i_out_valid && !i_in_stall, "pipeline not empty after reset")

endmodule

bind heightfield_triangle_height_query hftq_checker u_hftq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

// File: sim/hftq_checker.sv
// Checker for the heightfield triangle height query block: watches both item
// channels and the config port, predicts each query's height and compares.
// Depends on hftq_pkg.
`timescale 1ns / 1ps

module tb_hftq_checker import hftq_pkg::*; #(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int ONE       = 1 << FRACTION_BITS;
    localparam int STORE_LEN = MAX_SIDE * MAX_SIDE;

    // Shadow copy of the height store and the grid sizes
    logic [HEIGHT_BYTE_W-1:0] height_mem [0:STORE_LEN-1];
    logic [SIDE_W-1:0]        grid_w;
    logic [SIDE_W-1:0]        grid_d;

    // Heights still owed by the block, oldest first
    t_out_item expected_heights[$];

    int fail_count = 0;

    // Triangle interpolation of one query point
    function automatic t_out_item predict_height(input t_in_item it);
        int unsigned w, d, cx, cz, fx, fz, n, h;
        int unsigned ha, hb, hc;
        t_out_item   r;
        w  = (grid_w > MAX_SIDE) ? MAX_SIDE : grid_w;
        d  = (grid_d > MAX_SIDE) ? MAX_SIDE : grid_d;
        cx = it.query_x >> FRACTION_BITS;
        cz = it.query_z >> FRACTION_BITS;
        fx = it.query_x & (ONE - 1);
        fz = it.query_z & (ONE - 1);
        r  = '0;
        // far corner beyond the last row or column, or degenerate grid
        if (w < 2 || d < 2 || cx + 1 >= w || cz + 1 >= d) begin
            r.out_of_range = 1'b1;
            return r;
        end
        if (fx + fz > ONE) begin
            // upper-right triangle
            ha = height_mem[(cz + 1) * w + cx];
            hb = height_mem[(cz + 1) * w + cx + 1];
            hc = height_mem[cz * w + cx + 1];
            n  = ha * (ONE - fx) + hb * (fx + fz - ONE) + hc * (ONE - fz);
        end else begin
            // lower-left triangle
            ha = height_mem[cz * w + cx];
            hb = height_mem[cz * w + cx + 1];
            hc = height_mem[(cz + 1) * w + cx];
            n  = ha * (ONE - fx - fz) + hb * fx + hc * fz;
        end
        h = n / DIVISOR;
        if (h > HEIGHT_SAT) h = HEIGHT_SAT;
        r.height = h[HEIGHT_W-1:0];
        return r;
    endfunction

    // Sample at the falling edge: values then hold until the next rising edge
    always @(negedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            grid_w = SIDE_RESET;
            grid_d = SIDE_RESET;
            expected_heights.delete();
        end else begin
            // result item
            if (i_out_valid && !i_out_stall) begin
                if (expected_heights.size() == 0) begin
                    $error("result item with no query waiting: height %0d, out_of_range %0d",
                           i_out_item.height, i_out_item.out_of_range);
                    fail_count++;
                end else begin
                    want = expected_heights.pop_front();
                    if (i_out_item.height !== want.height) begin
                        $error("height mismatch: expected %0d, actual %0d",
                               want.height, i_out_item.height);
                        fail_count++;
                    end
                    if (i_out_item.out_of_range !== want.out_of_range) begin
                        $error("out_of_range mismatch: expected %0d, actual %0d",
                               want.out_of_range, i_out_item.out_of_range);
                        fail_count++;
                    end
                end
            end
            // register write
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_GRID_WIDTH) grid_w = i_cfg_data;
                else if (i_cfg_index == REG_GRID_DEPTH) grid_d = i_cfg_data;
            end
            // input item: store write or query
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.mode == MODE_QUERY) begin
                    expected_heights.push_back(predict_height(i_in_item));
                end else if (int'(i_in_item.cell_index) < STORE_LEN) begin
                    height_mem[i_in_item.cell_index] = i_in_item.height_value;
                end
            end
        end
        o_pending    = expected_heights.size();
        o_fail_count = fail_count;
    end

endmodule

// File: sim/tb_heightfield_triangle_height_query.sv
// Testbench top for the heightfield triangle height query block: clock, reset,
// item and config stimulus, receiver stalls and the verdict.
// Depends on hftq_pkg, heightfield_triangle_height_query and tb_hftq_checker.
`timescale 1ns / 1ps

module tb_heightfield_triangle_height_query import hftq_pkg::*;;

    localparam int LATENCY      = 6;
    localparam int LIMIT        = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 14;
    localparam int RANDOM_ITEMS = 1600;
    localparam int N_PHASES     = 12;
    localparam int N_FIXED      = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_stall;
    t_out_item            out_item;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIDE_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;

    // Grid settings per phase; the last phases pick random sizes
    int phase_w [0:N_FIXED-1] = '{2, 256, 256, 511, 0, 1, 5, 17, 256, 2};
    int phase_d [0:N_FIXED-1] = '{2, 256, 256, 300, 5, 256, 1, 9, 2, 256};

    // Effective grid sides seen by the block, and which store entries hold data
    int ew;
    int ed;
    bit written [0:65535];
    bit quiet;
    bit hold_req;
    bit hold_done;

    heightfield_triangle_height_query dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tb_hftq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested
    initial begin
        out_stall = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    function automatic int rand_height();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 255 : 0;
        return $urandom_range(0, 255);
    endfunction

    function automatic int rand_frac();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Offer one item, with random idle cycles first; returns at the accepting edge
    task automatic send_item(input t_in_item it);
        bit taken;
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    task automatic send_write(input int idx, input int val);
        t_in_item it;
        it.mode         = MODE_WRITE;
        it.cell_index   = CELL_IDX_W'(idx);
        it.height_value = HEIGHT_BYTE_W'(val);
        it.query_x      = QUERY_W'($urandom_range(0, 65535));
        it.query_z      = QUERY_W'($urandom_range(0, 65535));
        written[idx]    = 1'b1;
        send_item(it);
    endtask

    task automatic send_query(input int qx, input int qz);
        t_in_item it;
        it.mode         = MODE_QUERY;
        it.cell_index   = CELL_IDX_W'($urandom_range(0, 65535));
        it.height_value = HEIGHT_BYTE_W'($urandom_range(0, 255));
        it.query_x      = QUERY_W'(qx);
        it.query_z      = QUERY_W'(qz);
        send_item(it);
    endtask

    // Query inside a cell, first loading any corner that holds no data yet (every corner on refresh)
    task automatic query_cell(input int cx, input int cz, input int fx, input int fz,
                              input bit refresh, inout int sent);
        int idx, dx, dz;
        for (dz = 0; dz < 2; dz++) begin
            for (dx = 0; dx < 2; dx++) begin
                idx = (cz + dz) * ew + cx + dx;
                if (refresh || !written[idx]) begin
                    send_write(idx, rand_height());
                    sent++;
                end
            end
        end
        send_query((cx << 8) | fx, (cz << 8) | fz);
        sent++;
    endtask

    // Both sizes written on back-to-back edges while the block is idle
    task automatic set_grid(input int w, input int d);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= SIDE_W'(w);
        @(posedge clk);
        cfg_index <= REG_GRID_DEPTH;
        cfg_data  <= SIDE_W'(d);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ew = (w > 256) ? 256 : w;
        ed = (d > 256) ? 256 : d;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
    endtask

    // Stimulus
    initial begin
        int sent, sel, w, d, qx, qz, cx, cz, fx, fz, phase;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        hold_done = 1'b0;
        ew        = 256;
        ed        = 256;
        sent      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale cell, diagonal boundary, last cell, out of range
        send_write(0, 255);
        send_write(1, 255);
        send_write(256, 255);
        send_write(257, 255);
        send_query(16'h0000, 16'h0000);
        send_query(16'h00FF, 16'h00FF);
        send_query(16'h0080, 16'h0080);
        send_query(16'h0081, 16'h0080);
        send_write(254 * 256 + 254, 0);
        send_write(254 * 256 + 255, 255);
        send_write(255 * 256 + 254, 0);
        send_write(65535, 255);
        query_cell(254, 254, 255, 255, 1'b0, sent);
        send_query(16'hFE00, 16'hFE00);
        send_query(16'hFEFF, 16'hFE01);
        send_query(16'hFF00, 16'h0000);
        send_query(16'hFFFF, 16'hFFFF);
        send_query(16'h0000, 16'hFF80);
        in_valid <= 1'b0;
        drain();

        // Random phases, one grid setting each
        for (phase = 0; phase < N_PHASES; phase++) begin
            if (phase < N_FIXED) begin
                w = phase_w[phase];
                d = phase_d[phase];
            end else begin
                w = $urandom_range(0, 511);
                d = $urandom_range(0, 511);
            end
            set_grid(w, d);
            quiet = (phase == 1);
            if (phase == 2) hold_req = 1'b1;
            sent = 0;
            while (sent < RANDOM_ITEMS / N_PHASES) begin
                sel = $urandom_range(0, 99);
                if (ew >= 2 && ed >= 2 && sel < 70) begin
                    // well-formed query: corners loaded, then the point
                    cx = ($urandom_range(0, 3) == 0) ? ew - 2 : $urandom_range(0, ew - 2);
                    cz = ($urandom_range(0, 3) == 0) ? ed - 2 : $urandom_range(0, ed - 2);
                    fx = rand_frac();
                    case ($urandom_range(0, 3))
                        0:       fz = (256 - fx) & 255;
                        1:       fz = (257 - fx) & 255;
                        default: fz = rand_frac();
                    endcase
                    query_cell(cx, cz, fx, fz, $urandom_range(0, 2) == 0, sent);
                end else if (sel < 85) begin
                    // point forced into the last row or column
                    qx = $urandom_range(0, 65535);
                    qz = $urandom_range(0, 65535);
                    if (ew >= 2 && ed >= 2 && (qx >> 8) + 1 < ew && (qz >> 8) + 1 < ed) begin
                        if ($urandom_range(0, 1))
                            qx = ($urandom_range(ew - 1, 255) << 8) | (qx & 255);
                        else
                            qz = ($urandom_range(ed - 1, 255) << 8) | (qz & 255);
                    end
                    send_query(qx, qz);
                    sent++;
                end else begin
                    // stray store write anywhere
                    send_write($urandom_range(0, 65535), rand_height());
                    sent++;
                end
            end
            in_valid <= 1'b0;
            quiet = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/hftq_pkg.sv
hw/rtl/hftq_ram.sv
hw/rtl/hftq_addr.sv
hw/rtl/hftq_interp.sv
hw/rtl/heightfield_triangle_height_query.sv
hw/rtl/hftq_checker.sv
sim/hftq_checker.sv
sim/tb_heightfield_triangle_height_query.sv
